@@ rtl/core/cmap_sgb_pkg.sv @@
// ----------------------------------------------------------------------------
// cmap_sgb_pkg
// shared types, result kinds and the format 4 header helper for the
// cmap segment and group builder
// ----------------------------------------------------------------------------
package cmap_sgb_pkg;

	localparam logic [1:0] KIND_SEG   = 2'd0;
	localparam logic [1:0] KIND_GROUP = 2'd1;
	localparam logic [1:0] KIND_HDR   = 2'd2;
	localparam logic [1:0] KIND_COUNT = 2'd3;

	localparam logic [15:0] BMP_TOP = 16'hFFFF;

	// pending result slots of one queued op, in emission order
	localparam int unsigned SLOT_SEG   = 0;
	localparam int unsigned SLOT_SENT  = 1;
	localparam int unsigned SLOT_HDR   = 2;
	localparam int unsigned SLOT_GROUP = 3;
	localparam int unsigned SLOT_COUNT = 4;
	localparam int unsigned NUM_SLOTS  = 5;

	typedef struct packed {
		logic        fin;
		logic        seg_v;
		logic [15:0] seg_first;
		logic [15:0] seg_final;
		logic [15:0] seg_glyph;
		logic        sent_v;
		logic        grp_v;
		logic [20:0] grp_first;
		logic [20:0] grp_final;
		logic [15:0] grp_glyph;
		logic [15:0] seg_total;
		logic [20:0] grp_total;
	} op_t;

	// result payload, first member in the highest bits
	typedef struct packed {
		logic [4:0]  pad;
		logic [20:0] group_count;
		logic [15:0] range_shift;
		logic [3:0]  entry_selector;
		logic [15:0] search_range;
		logic [15:0] seg_count_x2;
		logic [15:0] id_delta;
		logic [15:0] start_glyph;
		logic [20:0] run_end;
		logic [20:0] run_start;
	} res_t;

	typedef struct packed {
		logic [15:0] seg_count_x2;
		logic [15:0] search_range;
		logic [3:0]  entry_selector;
		logic [15:0] range_shift;
	} hdr_t;

	function automatic hdr_t calc_hdr(input logic [15:0] seg_total);
		hdr_t        h;
		logic [14:0] n;
		logic [3:0]  es;
		n  = seg_total[14:0];
		es = 4'd0;
		for (int i = 1; i < 15; i++) begin
			if (n[i]) begin
				es = 4'(i);
			end
		end
		h.seg_count_x2   = {n, 1'b0};
		h.entry_selector = es;
		h.search_range   = 16'd2 << es;
		h.range_shift    = h.seg_count_x2 - h.search_range;
		return h;
	endfunction

endpackage

@@ rtl/core/cmap_sgb_front.sv @@
// ----------------------------------------------------------------------------
// cmap_sgb_front
// accepts mapping entries and finish commands, tracks the open segment and
// group runs, and queues one op per item naming the results it causes
// ----------------------------------------------------------------------------
module cmap_sgb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,   // codepoint[20:0], glyph[36:21], zero pad
	input  logic                s_tuser,   // cmd
	output logic                op_valid,
	input  logic                op_ready,
	output cmap_sgb_pkg::op_t   op
);

	logic        bmp_open_q;
	logic [15:0] bmp_first_q;
	logic [15:0] bmp_final_q;
	logic [15:0] bmp_glyph_q;
	logic [16:0] bmp_exp_q;
	logic [15:0] bmp_total_q;
	logic        full_open_q;
	logic [20:0] full_first_q;
	logic [20:0] full_final_q;
	logic [15:0] full_glyph_q;
	logic [16:0] full_exp_q;
	logic [20:0] full_total_q;

	logic        fin;
	logic [20:0] cp;
	logic [15:0] gl;
	logic [16:0] gl_next;
	logic        bmp_in;
	logic        bmp_ext;
	logic        full_ext;
	logic        accept;

	assign fin      = s_tuser;
	assign cp       = s_tdata[20:0];
	assign gl       = s_tdata[36:21];
	assign gl_next  = {1'b0, gl} + 17'd1;
	assign bmp_in   = (cp[20:16] == 5'd0);
	assign bmp_ext  = bmp_open_q && (({1'b0, bmp_final_q} + 17'd1) == cp[16:0])
		&& (bmp_exp_q == {1'b0, gl});
	assign full_ext = full_open_q && (({1'b0, full_final_q} + 22'd1) == {1'b0, cp})
		&& (full_exp_q == {1'b0, gl});

	assign s_tready = op_ready;
	assign op_valid = s_tvalid;
	assign accept   = s_tvalid && op_ready;

	always_comb begin
		op.fin       = fin;
		op.seg_first = bmp_first_q;
		op.seg_final = bmp_final_q;
		op.seg_glyph = bmp_glyph_q;
		op.grp_first = full_first_q;
		op.grp_final = full_final_q;
		op.grp_glyph = full_glyph_q;
		if (fin) begin
			op.seg_v  = bmp_open_q;
			op.sent_v = !(bmp_open_q && (bmp_final_q == cmap_sgb_pkg::BMP_TOP));
			op.grp_v  = full_open_q;
		end else begin
			op.seg_v  = bmp_in && bmp_open_q && !bmp_ext;
			op.sent_v = 1'b0;
			op.grp_v  = full_open_q && !full_ext;
		end
		op.seg_total = bmp_total_q + {15'd0, op.seg_v} + {15'd0, op.sent_v};
		op.grp_total = full_total_q + {20'd0, op.grp_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmp_open_q   <= 1'b0;
			bmp_total_q  <= '0;
			full_open_q  <= 1'b0;
			full_total_q <= '0;
		end else if (accept) begin
			if (fin) begin
				bmp_open_q   <= 1'b0;
				bmp_total_q  <= '0;
				full_open_q  <= 1'b0;
				full_total_q <= '0;
			end else begin
				if (bmp_in) begin
					bmp_open_q <= 1'b1;
				end
				bmp_total_q  <= op.seg_total;
				full_open_q  <= 1'b1;
				full_total_q <= op.grp_total;
			end
		end
	end

	// run payload, only read while the run is open
	always_ff @(posedge clk) begin
		if (accept && !fin) begin
			if (bmp_in) begin
				bmp_final_q <= cp[15:0];
				bmp_exp_q   <= gl_next;
				if (!bmp_ext) begin
					bmp_first_q <= cp[15:0];
					bmp_glyph_q <= gl;
				end
			end
			full_final_q <= cp;
			full_exp_q   <= gl_next;
			if (!full_ext) begin
				full_first_q <= cp;
				full_glyph_q <= gl;
			end
		end
	end

endmodule

@@ rtl/core/cmap_sgb_fifo.sv @@
// ----------------------------------------------------------------------------
// cmap_sgb_fifo
// short op queue between the front and back parts
// ----------------------------------------------------------------------------
module cmap_sgb_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmap_sgb_pkg::op_t in_op,
	output logic              out_valid,
	input  logic              out_pop,
	output cmap_sgb_pkg::op_t out_op
);

	localparam int unsigned IdxW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	cmap_sgb_pkg::op_t mem_q [DEPTH];
	logic [IdxW-1:0]   wr_q;
	logic [IdxW-1:0]   rd_q;
	logic [CntW-1:0]   cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != CntW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_op    = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IdxW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IdxW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_op;
		end
	end

endmodule

@@ rtl/core/cmap_sgb_back.sv @@
// ----------------------------------------------------------------------------
// cmap_sgb_back
// expands each queued op into its result items, one per cycle while the
// output drains, into a registered output stage
// ----------------------------------------------------------------------------
module cmap_sgb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_pop,
	input  cmap_sgb_pkg::op_t   op,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [151:0]        m_tdata,   // run_start, run_end, start_glyph, id_delta,
	                                       // seg_count_x2, search_range, entry_selector,
	                                       // range_shift, group_count, zero pad
	output logic [1:0]          m_tuser,   // kind
	output logic                m_tlast
);

	localparam int unsigned NS = cmap_sgb_pkg::NUM_SLOTS;

	logic                 cur_v_q;
	cmap_sgb_pkg::op_t    cur_q;
	logic [NS-1:0]        mask_q;
	logic                 out_v_q;
	cmap_sgb_pkg::res_t   res_q;
	logic [1:0]           kind_q;
	logic                 last_q;

	logic [NS-1:0]        low;
	logic [NS-1:0]        rest;
	logic [NS-1:0]        load_mask;
	logic                 slot_free;
	logic                 emit;
	logic                 done;
	logic                 load;
	cmap_sgb_pkg::hdr_t   hdr;
	cmap_sgb_pkg::res_t   res;
	logic [1:0]           kind;

	assign low       = mask_q & (~mask_q + 1'b1);
	assign rest      = mask_q & ~low;
	assign slot_free = !out_v_q || m_tready;
	assign emit      = cur_v_q && (mask_q != '0) && slot_free;
	assign done      = cur_v_q && ((mask_q == '0) || (emit && (rest == '0)));
	assign load      = (!cur_v_q || done) && op_valid;
	assign op_pop    = load;
	assign hdr       = cmap_sgb_pkg::calc_hdr(cur_q.seg_total);

	always_comb begin
		load_mask = '0;
		load_mask[cmap_sgb_pkg::SLOT_SEG]   = op.seg_v;
		load_mask[cmap_sgb_pkg::SLOT_SENT]  = op.fin && op.sent_v;
		load_mask[cmap_sgb_pkg::SLOT_HDR]   = op.fin;
		load_mask[cmap_sgb_pkg::SLOT_GROUP] = op.grp_v;
		load_mask[cmap_sgb_pkg::SLOT_COUNT] = op.fin;
	end

	always_comb begin
		res  = '0;
		kind = cmap_sgb_pkg::KIND_SEG;
		if (low[cmap_sgb_pkg::SLOT_SEG]) begin
			res.run_start   = {5'd0, cur_q.seg_first};
			res.run_end     = {5'd0, cur_q.seg_final};
			res.start_glyph = cur_q.seg_glyph;
			res.id_delta    = cur_q.seg_glyph - cur_q.seg_first;
		end else if (low[cmap_sgb_pkg::SLOT_SENT]) begin
			res.run_start   = {5'd0, cmap_sgb_pkg::BMP_TOP};
			res.run_end     = {5'd0, cmap_sgb_pkg::BMP_TOP};
			res.id_delta    = 16'd0 - cmap_sgb_pkg::BMP_TOP;
		end else if (low[cmap_sgb_pkg::SLOT_HDR]) begin
			kind               = cmap_sgb_pkg::KIND_HDR;
			res.seg_count_x2   = hdr.seg_count_x2;
			res.search_range   = hdr.search_range;
			res.entry_selector = hdr.entry_selector;
			res.range_shift    = hdr.range_shift;
		end else if (low[cmap_sgb_pkg::SLOT_GROUP]) begin
			kind            = cmap_sgb_pkg::KIND_GROUP;
			res.run_start   = cur_q.grp_first;
			res.run_end     = cur_q.grp_final;
			res.start_glyph = cur_q.grp_glyph;
		end else if (low[cmap_sgb_pkg::SLOT_COUNT]) begin
			kind            = cmap_sgb_pkg::KIND_COUNT;
			res.group_count = cur_q.grp_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			mask_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				cur_v_q <= 1'b1;
				mask_q  <= load_mask;
			end else if (done) begin
				cur_v_q <= 1'b0;
				mask_q  <= '0;
			end else if (emit) begin
				mask_q  <= rest;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= op;
		end
		if (emit) begin
			res_q  <= res;
			kind_q <= kind;
			last_q <= (rest == '0);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = res_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

@@ rtl/core/cmap_segment_group_builder.sv @@
// ----------------------------------------------------------------------------
// cmap_segment_group_builder
// builds cmap format 4 segments and format 12 groups from a sorted stream
// of (codepoint, glyph) entries
// ----------------------------------------------------------------------------
// Entries must arrive in ascending codepoint order; the block does not sort.
// A mapping entry is taken in any cycle that s_tready is high and causes
// zero, one or two result items (the closed BMP segment, then the closed
// group). A finish command flushes both runs and gives three to five
// items: open segment, sentinel segment, header values, open group, group
// count, the last one marked with tlast; state then clears for the next
// map. Results leave one per cycle from a registered output while results
// drain, so input is one item per cycle while each causes one result; the op
// queue (QUEUE_DEPTH ops) absorbs stalls and extra items until s_tready drops.
module cmap_segment_group_builder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // codepoint[20:0], glyph[36:21], zero pad
	input  logic         s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // run_start, run_end, start_glyph, id_delta,
	                                // seg_count_x2, search_range, entry_selector,
	                                // range_shift, group_count, zero pad
	output logic [1:0]   m_tuser,   // kind
	output logic         m_tlast
);

	cmap_sgb_pkg::op_t front_op;
	cmap_sgb_pkg::op_t queue_op;
	logic              front_valid;
	logic              queue_ready;
	logic              queue_valid;
	logic              queue_pop;

	cmap_sgb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.op_valid (front_valid),
		.op_ready (queue_ready),
		.op       (front_op)
	);

	cmap_sgb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (queue_ready),
		.in_op     (front_op),
		.out_valid (queue_valid),
		.out_pop   (queue_pop),
		.out_op    (queue_op)
	);

	cmap_sgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (queue_valid),
		.op_pop   (queue_pop),
		.op       (queue_op),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ bench/cmap_segment_group_builder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_segment_group_builder_tb
// self-checking bench for the cmap segment and group builder: directed maps
// cover the code point and glyph extremes, the sentinel cases and runs that
// cross the end of the BMP, then random maps of ascending runs mixed with
// unsorted noise run under changing source gaps and sink stalls; every
// result item is checked field by field against a software model of the
// two open runs
// ----------------------------------------------------------------------------
module cmap_segment_group_builder_tb;

	localparam logic CMD_ENTRY  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct {
		logic [1:0]  kind;
		logic [20:0] run_start;
		logic [20:0] run_end;
		logic [15:0] start_glyph;
		logic [15:0] id_delta;
		logic [15:0] seg_count_x2;
		logic [15:0] search_range;
		logic [3:0]  entry_selector;
		logic [15:0] range_shift;
		logic [20:0] group_count;
		logic        last_result;
	} map_result_t;

	class cmap_scoreboard;
		map_result_t pending[$];
		map_result_t fresh[$];
		int          errors;

		logic        bmp_open;
		logic [15:0] bmp_first, bmp_final, bmp_glyph, bmp_total;
		logic        full_open;
		logic [20:0] full_first, full_final, full_total;
		logic [15:0] full_glyph;

		function new();
			errors = 0;
			clear_runs();
		endfunction

		function void clear_runs();
			bmp_open   = 1'b0;
			bmp_first  = '0;
			bmp_final  = '0;
			bmp_glyph  = '0;
			bmp_total  = '0;
			full_open  = 1'b0;
			full_first = '0;
			full_final = '0;
			full_glyph = '0;
			full_total = '0;
		endfunction

		function map_result_t blank(logic [1:0] kind);
			map_result_t r;
			r.kind           = kind;
			r.run_start      = '0;
			r.run_end        = '0;
			r.start_glyph    = '0;
			r.id_delta       = '0;
			r.seg_count_x2   = '0;
			r.search_range   = '0;
			r.entry_selector = '0;
			r.range_shift    = '0;
			r.group_count    = '0;
			r.last_result    = 1'b0;
			return r;
		endfunction

		function void add_segment(logic [15:0] first, logic [15:0] final_cp, logic [15:0] glyph);
			map_result_t r;
			r             = blank(cmap_sgb_pkg::KIND_SEG);
			r.run_start   = {5'd0, first};
			r.run_end     = {5'd0, final_cp};
			r.start_glyph = glyph;
			r.id_delta    = glyph - first;
			fresh.insert(fresh.size(), r);
			bmp_total = bmp_total + 16'd1;
		endfunction

		function void add_group();
			map_result_t r;
			r             = blank(cmap_sgb_pkg::KIND_GROUP);
			r.run_start   = full_first;
			r.run_end     = full_final;
			r.start_glyph = full_glyph;
			fresh.insert(fresh.size(), r);
			full_total = full_total + 21'd1;
		endfunction

		function void note_input(logic cmd, logic [20:0] cp, logic [15:0] gl);
			map_result_t  r;
			logic         at_top;
			logic [15:0]  sx2;
			int unsigned  sr;
			int unsigned  es;
			fresh.delete();
			if (cmd == CMD_ENTRY) begin
				if (cp <= 21'(cmap_sgb_pkg::BMP_TOP)) begin
					if (bmp_open && 32'(bmp_final) + 1 == 32'(cp)
					    && 32'(bmp_glyph) + 32'(bmp_final) - 32'(bmp_first) + 1 == 32'(gl)) begin
						bmp_final = cp[15:0];
					end else begin
						if (bmp_open) begin
							add_segment(bmp_first, bmp_final, bmp_glyph);
						end
						bmp_open  = 1'b1;
						bmp_first = cp[15:0];
						bmp_final = cp[15:0];
						bmp_glyph = gl;
					end
				end
				if (full_open && 32'(full_final) + 1 == 32'(cp)
				    && 32'(full_glyph) + 32'(full_final) - 32'(full_first) + 1 == 32'(gl)) begin
					full_final = cp;
				end else begin
					if (full_open) begin
						add_group();
					end
					full_open  = 1'b1;
					full_first = cp;
					full_final = cp;
					full_glyph = gl;
				end
			end else begin
				at_top = 1'b0;
				if (bmp_open) begin
					add_segment(bmp_first, bmp_final, bmp_glyph);
					at_top = (bmp_final == cmap_sgb_pkg::BMP_TOP);
				end
				if (!at_top) begin
					add_segment(cmap_sgb_pkg::BMP_TOP, cmap_sgb_pkg::BMP_TOP, 16'd0);
				end
				sx2 = bmp_total << 1;
				sr  = 2;
				es  = 0;
				while (sr * 2 <= 32'(sx2)) begin
					sr = sr * 2;
					es++;
				end
				r                = blank(cmap_sgb_pkg::KIND_HDR);
				r.seg_count_x2   = sx2;
				r.search_range   = 16'(sr);
				r.entry_selector = 4'(es);
				r.range_shift    = sx2 - 16'(sr);
				fresh.insert(fresh.size(), r);
				if (full_open) begin
					add_group();
				end
				r             = blank(cmap_sgb_pkg::KIND_COUNT);
				r.group_count = full_total;
				fresh.insert(fresh.size(), r);
				clear_runs();
			end
			if (fresh.size() > 0) begin
				fresh[fresh.size() - 1].last_result = 1'b1;
			end
			foreach (fresh[i]) begin
				pending.insert(pending.size(), fresh[i]);
			end
		endfunction

		function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [151:0] data, logic last_flag);
			map_result_t e;
			if (pending.size() == 0) begin
				$error("result item of kind %0d with nothing expected", kind);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("kind", 32'(e.kind), 32'(kind));
			cmp("run_start", 32'(e.run_start), 32'(data[20:0]));
			cmp("run_end", 32'(e.run_end), 32'(data[41:21]));
			cmp("start_glyph", 32'(e.start_glyph), 32'(data[57:42]));
			cmp("id_delta", 32'(e.id_delta), 32'(data[73:58]));
			cmp("seg_count_x2", 32'(e.seg_count_x2), 32'(data[89:74]));
			cmp("search_range", 32'(e.search_range), 32'(data[105:90]));
			cmp("entry_selector", 32'(e.entry_selector), 32'(data[109:106]));
			cmp("range_shift", 32'(e.range_shift), 32'(data[125:110]));
			cmp("group_count", 32'(e.group_count), 32'(data[146:126]));
			cmp("last_result", 32'(e.last_result), 32'(last_flag));
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [151:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	cmap_scoreboard sb;
	int             idle_pct;
	int             stall_pct;
	int             items_sent;

	cmap_segment_group_builder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_input(s_tuser, s_tdata[20:0], s_tdata[36:21]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tuser, m_tdata, m_tlast);
			end
		end
	end

	task automatic send_item(input logic cmd, input logic [20:0] cp, input logic [15:0] gl);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct) begin
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'd0, gl, cp};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// ascending runs with gaps, jumps past the bmp and some unsorted noise
	task automatic random_map(input int n);
		logic [20:0] cp;
		logic [15:0] gl;
		int          r;
		case ($urandom_range(0, 2))
			0: cp = 21'($urandom_range(0, 16'hFF00));
			1: cp = 21'($urandom_range(16'hFFF0, 16'hFFFF));
			default: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
		endcase
		gl = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			send_item(CMD_ENTRY, cp, gl);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				cp = cp + 21'd1;
				gl = gl + 16'd1;
			end else if (r < 80) begin
				cp = cp + 21'($urandom_range(1, 64));
				gl = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
				                                : 16'($urandom);
			end else if (r < 88) begin
				cp = cp + 21'($urandom_range(1, 21'h40000));
				gl = 16'($urandom);
			end else if (r < 94) begin
				gl = ($urandom_range(0, 1) == 0) ? gl : 16'($urandom);
			end else begin
				cp = 21'($urandom);
				gl = 16'($urandom);
			end
		end
		send_item(CMD_FINISH, 21'($urandom), 16'($urandom));
	endtask

	initial begin
		sb         = new();
		idle_pct   = 0;
		stall_pct  = 0;
		items_sent = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_ENTRY;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty map: sentinel only
		send_item(CMD_FINISH, 21'd0, 16'd0);
		// extend, repeat, out of order, glyph past its top, bmp edge
		send_item(CMD_ENTRY, 21'd0, 16'd0);
		send_item(CMD_ENTRY, 21'd1, 16'd1);
		send_item(CMD_ENTRY, 21'd2, 16'd2);
		send_item(CMD_ENTRY, 21'd2, 16'd2);
		send_item(CMD_ENTRY, 21'd1, 16'd5);
		send_item(CMD_ENTRY, 21'hFFFE, 16'hFFFF);
		send_item(CMD_ENTRY, 21'hFFFF, 16'h0000);
		send_item(CMD_ENTRY, 21'h10000, 16'h0001);
		send_item(CMD_ENTRY, 21'h10FFFF, 16'hFFFF);
		send_item(CMD_ENTRY, 21'h1FFFFF, 16'h1234);
		send_item(CMD_FINISH, 21'h1FFFFF, 16'hFFFF);
		// run crossing the end of the bmp
		send_item(CMD_ENTRY, 21'hFFFE, 16'd10);
		send_item(CMD_ENTRY, 21'hFFFF, 16'd11);
		send_item(CMD_ENTRY, 21'h10000, 16'd12);
		send_item(CMD_FINISH, 21'd0, 16'd0);
		// supplementary only
		send_item(CMD_ENTRY, 21'h1FFFFF, 16'h0000);
		send_item(CMD_FINISH, 21'h0AAAAA, 16'h5555);
		// bmp run ending below the top
		send_item(CMD_ENTRY, 21'h0041, 16'hFFFE);
		send_item(CMD_ENTRY, 21'h0042, 16'hFFFF);
		send_item(CMD_FINISH, 21'd0, 16'd0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			while (items_sent < 21 + 19 * (phase + 1)) begin
				random_map($urandom_range(0, 12));
			end
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
